FILE: rtl/batch_block_format_validator_core_macros.svh
// ----------------------------------------------------------------------------
// batch_block_format_validator_core_macros
// Assertion macros shared by the validator RTL.
// ----------------------------------------------------------------------------
`ifndef BATCH_BLOCK_FORMAT_VALIDATOR_CORE_MACROS_SVH
`define BATCH_BLOCK_FORMAT_VALIDATOR_CORE_MACROS_SVH
// Assert that antecedent implies consequent on the same edge.
`define BBFV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Assert that antecedent implies consequent on the next edge.
`define BBFV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/bbfv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbfv_pkg
// Types and constants shared by the batch block format validator.
// ----------------------------------------------------------------------------
package bbfv_pkg;

  localparam int unsigned ID_BYTES_DEF   = 32;
  localparam int unsigned HASH_BYTES     = 32;
  localparam int unsigned CNT_W          = 21;
  localparam logic [CNT_W-1:0] COUNT_MAX = 21'h1FFFFF;
  localparam logic [63:0] SIZE_LIMIT     = 64'h0000_0000_0200_0000;

  typedef enum logic [3:0] {
    PH_VER, PH_BATCH, PH_KLEN, PH_KEY, PH_EXP, PH_ROOT, PH_NENT, PH_EID,
    PH_ECON, PH_EDEST, PH_NOUT, PH_OVAL, PH_DONE, PH_ERR
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_TOO_LONG  = 4'd1,
    ST_VERSION   = 4'd2,
    ST_MALFORMED = 4'd3,
    ST_OVER_CAP  = 4'd4,
    ST_KEY_LEN   = 4'd5,
    ST_NO_ENTRY  = 4'd6,
    ST_NEG_CONTR = 4'd7,
    ST_ORDER     = 4'd8,
    ST_NO_OUTPUT = 4'd9,
    ST_NEG_VALUE = 4'd10,
    ST_TRUNC     = 4'd11,
    ST_TRAILING  = 4'd12,
    ST_INDEX     = 4'd13
  } status_t;

  typedef enum logic [1:0] {
    CFG_VERSION = 2'd0,
    CFG_KEY_LEN = 2'd1,
    CFG_MAX_LEN = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMP_EQUAL = 2'd0,
    CMP_LESS  = 2'd1,
    CMP_MORE  = 2'd2
  } id_cmp_t;

endpackage

FILE: rtl/batch_block_format_validator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batch_block_format_validator_core
// Byte-serial strict format checker for serialized batch blocks.
// ----------------------------------------------------------------------------
// Takes one byte word per cycle, back to back, and returns one status word
// per block on the cycle after the byte marked last is taken. Each byte is
// decoded by a single registered step over the per-field counters, so the
// rate is one byte per clock while in_stall is low. A one-deep output
// register holds the result while out_stall is high; in_stall rises only
// when that register is full and stalled. The previous entry id is kept in
// an ID_BYTES deep byte store; the byte for the next index is read ahead
// into a register, and each new id byte is written in place as the id
// streams through.
`include "batch_block_format_validator_core_macros.svh"

module batch_block_format_validator_core #(
  parameter int unsigned ID_BYTES = bbfv_pkg::ID_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [20:0] out_entry_count,
  output logic [20:0] out_output_count
);

  localparam int unsigned IDX_W = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;

  // Configuration registers.
  logic [7:0]  exp_ver_r;
  logic [11:0] key_len_r;
  logic [20:0] max_len_r;

  // Stream state.
  bbfv_pkg::phase_t  phase_r,  phase_nxt;
  logic [11:0]       fbc_r,    fbc_nxt;
  logic [63:0]       acc_r,    acc_nxt;
  logic [3:0]        need_r,   need_nxt;
  bbfv_pkg::id_cmp_t cmp_r,    cmp_nxt;
  logic [20:0]       total_r,  total_nxt;
  logic              long_r,   long_nxt;
  logic [20:0]       left_r,   left_nxt;
  logic [31:0]       maxd_r,   maxd_nxt;
  logic [20:0]       ecnt_r,   ecnt_nxt;
  logic [20:0]       ocnt_r,   ocnt_nxt;
  logic [3:0]        err_r,    err_nxt;

  logic [7:0] prev_id_mem [ID_BYTES];

  // Output register.
  logic        ov_r;
  logic [3:0]  ost_r,  ost_nxt;
  logic [20:0] oec_r,  ooc_r;

  logic accept;
  assign in_stall = ov_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Compact-size decode for the current byte.
  logic        cs_done, cs_bad;
  logic [63:0] cs_val, acc_or, cs_min;
  logic [11:0] fbc_inc;
  logic [7:0]  b;
  logic        first_ent;
  logic [IDX_W-1:0] id_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [7:0]  prev_r;
  logic        id_byte;

  assign b         = in_data_byte;
  assign fbc_inc   = fbc_r + 12'd1;
  assign first_ent = (left_r == ecnt_r);
  assign id_byte   = (fbc_r < 12'(ID_BYTES));
  assign id_idx    = fbc_r[IDX_W-1:0];

  always_comb begin
    acc_or  = acc_r | (64'(b) << {fbc_r[2:0] - 3'd1, 3'b000});
    cs_done = 1'b0;
    cs_bad  = 1'b0;
    cs_val  = 64'(b);
    cs_min  = (need_r == 4'd2) ? 64'd253 :
              (need_r == 4'd4) ? 64'h1_0000 : 64'h1_0000_0000;
    if (fbc_r == 12'd0) begin
      cs_done = (b < 8'd253);
    end else if (fbc_r >= 12'(need_r)) begin
      cs_done = 1'b1;
      cs_val  = acc_or;
      cs_bad  = (acc_or < cs_min) || (acc_or > bbfv_pkg::SIZE_LIMIT);
    end
  end

  // Per-byte step.
  always_comb begin
    logic [20:0] tot_i;
    phase_nxt = phase_r;
    fbc_nxt   = fbc_r;
    acc_nxt   = acc_r;
    need_nxt  = need_r;
    cmp_nxt   = cmp_r;
    left_nxt  = left_r;
    maxd_nxt  = maxd_r;
    ecnt_nxt  = ecnt_r;
    ocnt_nxt  = ocnt_r;
    err_nxt   = err_r;
    tot_i     = (total_r < bbfv_pkg::COUNT_MAX) ? total_r + 21'd1 : total_r;
    total_nxt = tot_i;
    long_nxt  = long_r | (tot_i > max_len_r);

    // Compact-size bookkeeping shared by all size fields.
    if (phase_r == bbfv_pkg::PH_KLEN || phase_r == bbfv_pkg::PH_NENT ||
        phase_r == bbfv_pkg::PH_EDEST || phase_r == bbfv_pkg::PH_NOUT) begin
      if (fbc_r == 12'd0) begin
        if (!cs_done) begin
          need_nxt = (b == 8'd253) ? 4'd2 : (b == 8'd254) ? 4'd4 : 4'd8;
          acc_nxt  = '0;
          fbc_nxt  = 12'd1;
        end
      end else begin
        acc_nxt = acc_or;
        fbc_nxt = cs_done ? 12'd0 : fbc_inc;
      end
    end

    case (phase_r)
      bbfv_pkg::PH_VER: begin
        if (b != exp_ver_r) begin
          err_nxt = bbfv_pkg::ST_VERSION; phase_nxt = bbfv_pkg::PH_ERR;
        end else begin
          phase_nxt = bbfv_pkg::PH_BATCH;
        end
      end
      bbfv_pkg::PH_BATCH, bbfv_pkg::PH_ROOT: begin
        if (fbc_inc >= 12'(bbfv_pkg::HASH_BYTES)) begin
          fbc_nxt   = '0;
          phase_nxt = (phase_r == bbfv_pkg::PH_BATCH) ? bbfv_pkg::PH_KLEN
                                                      : bbfv_pkg::PH_NENT;
        end else fbc_nxt = fbc_inc;
      end
      bbfv_pkg::PH_KLEN: begin
        if (cs_done) begin
          if (cs_bad) begin
            err_nxt = bbfv_pkg::ST_MALFORMED; phase_nxt = bbfv_pkg::PH_ERR;
          end else if (cs_val > 64'(key_len_r)) begin
            err_nxt = bbfv_pkg::ST_OVER_CAP; phase_nxt = bbfv_pkg::PH_ERR;
          end else if (cs_val != 64'(key_len_r)) begin
            err_nxt = bbfv_pkg::ST_KEY_LEN; phase_nxt = bbfv_pkg::PH_ERR;
          end else begin
            phase_nxt = (key_len_r == 12'd0) ? bbfv_pkg::PH_EXP : bbfv_pkg::PH_KEY;
          end
        end
      end
      bbfv_pkg::PH_KEY: begin
        if (fbc_inc >= key_len_r) begin
          fbc_nxt = '0; phase_nxt = bbfv_pkg::PH_EXP;
        end else fbc_nxt = fbc_inc;
      end
      bbfv_pkg::PH_EXP: begin
        if (fbc_inc >= 12'd4) begin
          fbc_nxt = '0; phase_nxt = bbfv_pkg::PH_ROOT;
        end else fbc_nxt = fbc_inc;
      end
      bbfv_pkg::PH_NENT, bbfv_pkg::PH_NOUT: begin
        if (cs_done) begin
          if (cs_bad) begin
            err_nxt = bbfv_pkg::ST_MALFORMED; phase_nxt = bbfv_pkg::PH_ERR;
          end else if (cs_val > 64'(max_len_r)) begin
            err_nxt = bbfv_pkg::ST_OVER_CAP; phase_nxt = bbfv_pkg::PH_ERR;
          end else if (cs_val == 64'd0) begin
            err_nxt = (phase_r == bbfv_pkg::PH_NENT) ? bbfv_pkg::ST_NO_ENTRY
                                                     : bbfv_pkg::ST_NO_OUTPUT;
            phase_nxt = bbfv_pkg::PH_ERR;
          end else if (phase_r == bbfv_pkg::PH_NENT) begin
            ecnt_nxt  = cs_val[20:0];
            left_nxt  = cs_val[20:0];
            phase_nxt = bbfv_pkg::PH_EID;
            cmp_nxt   = bbfv_pkg::CMP_EQUAL;
            fbc_nxt   = '0;
          end else begin
            ocnt_nxt  = cs_val[20:0];
            left_nxt  = cs_val[20:0];
            phase_nxt = bbfv_pkg::PH_OVAL;
            fbc_nxt   = '0;
          end
        end
      end
      bbfv_pkg::PH_EID: begin
        // Compare byte by byte against the previous id until they differ.
        if (id_byte && !first_ent && cmp_r == bbfv_pkg::CMP_EQUAL) begin
          if (prev_r < b)      cmp_nxt = bbfv_pkg::CMP_LESS;
          else if (prev_r > b) cmp_nxt = bbfv_pkg::CMP_MORE;
        end
        if (fbc_inc >= 12'(ID_BYTES)) begin
          fbc_nxt = '0; phase_nxt = bbfv_pkg::PH_ECON;
        end else fbc_nxt = fbc_inc;
      end
      bbfv_pkg::PH_ECON, bbfv_pkg::PH_OVAL: begin
        if (fbc_r == 12'd7 && b[7]) begin
          fbc_nxt   = '0;
          err_nxt   = (phase_r == bbfv_pkg::PH_ECON) ? bbfv_pkg::ST_NEG_CONTR
                                                     : bbfv_pkg::ST_NEG_VALUE;
          phase_nxt = bbfv_pkg::PH_ERR;
        end else if (fbc_inc >= 12'd8) begin
          fbc_nxt = '0;
          if (phase_r == bbfv_pkg::PH_ECON) phase_nxt = bbfv_pkg::PH_EDEST;
          else begin
            left_nxt = left_r - 21'd1;
            if (left_r == 21'd1) phase_nxt = bbfv_pkg::PH_DONE;
          end
        end else fbc_nxt = fbc_inc;
      end
      bbfv_pkg::PH_EDEST: begin
        if (cs_done) begin
          if (cs_bad) begin
            err_nxt = bbfv_pkg::ST_MALFORMED; phase_nxt = bbfv_pkg::PH_ERR;
          end else if (!first_ent && cmp_r != bbfv_pkg::CMP_LESS) begin
            err_nxt = bbfv_pkg::ST_ORDER; phase_nxt = bbfv_pkg::PH_ERR;
          end else begin
            if (cs_val[31:0] > maxd_r) maxd_nxt = cs_val[31:0];
            left_nxt = left_r - 21'd1;
            fbc_nxt  = '0;
            if (left_r == 21'd1) phase_nxt = bbfv_pkg::PH_NOUT;
            else begin
              phase_nxt = bbfv_pkg::PH_EID;
              cmp_nxt   = bbfv_pkg::CMP_EQUAL;
            end
          end
        end
      end
      bbfv_pkg::PH_DONE: begin
        err_nxt = bbfv_pkg::ST_TRAILING; phase_nxt = bbfv_pkg::PH_ERR;
      end
      default: ;
    endcase

    // Status priority: length, first error, truncation, index range.
    if (long_nxt)                          ost_nxt = bbfv_pkg::ST_TOO_LONG;
    else if (err_nxt != bbfv_pkg::ST_OK)   ost_nxt = err_nxt;
    else if (phase_nxt != bbfv_pkg::PH_DONE) ost_nxt = bbfv_pkg::ST_TRUNC;
    else if (32'(ocnt_nxt) <= maxd_nxt)    ost_nxt = bbfv_pkg::ST_INDEX;
    else                                   ost_nxt = bbfv_pkg::ST_OK;
  end

  // Read ahead: fetch the byte for the index the next accepted word will use.
  assign rd_idx = accept ? fbc_nxt[IDX_W-1:0] : fbc_r[IDX_W-1:0];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ver_r <= 8'd1;
      key_len_r <= 12'd897;
      max_len_r <= 21'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        bbfv_pkg::CFG_VERSION: exp_ver_r <= cfg_wdata[7:0];
        bbfv_pkg::CFG_KEY_LEN: key_len_r <= cfg_wdata[11:0];
        bbfv_pkg::CFG_MAX_LEN: max_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stream state: advance on each accepted byte, clear after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_last)) begin
      phase_r <= bbfv_pkg::PH_VER;
      fbc_r   <= '0;
      acc_r   <= '0;
      need_r  <= '0;
      cmp_r   <= bbfv_pkg::CMP_EQUAL;
      total_r <= '0;
      long_r  <= 1'b0;
      left_r  <= '0;
      maxd_r  <= '0;
      ecnt_r  <= '0;
      ocnt_r  <= '0;
      err_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      fbc_r   <= fbc_nxt;
      acc_r   <= acc_nxt;
      need_r  <= need_nxt;
      cmp_r   <= cmp_nxt;
      total_r <= total_nxt;
      long_r  <= long_nxt;
      left_r  <= left_nxt;
      maxd_r  <= maxd_nxt;
      ecnt_r  <= ecnt_nxt;
      ocnt_r  <= ocnt_nxt;
      err_r   <= err_nxt;
    end
  end

  // Previous-id store: overwrite in place as the new id streams in.
  always_ff @(posedge clk) begin
    if (accept && phase_r == bbfv_pkg::PH_EID && id_byte) prev_id_mem[id_idx] <= b;
    prev_r <= prev_id_mem[rd_idx];
  end

  // Result register: hold while stalled, load on the last byte.
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (accept && in_last) ov_r <= 1'b1;
    else if (!out_stall) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (accept && in_last) begin
      ost_r <= ost_nxt;
      oec_r <= ecnt_nxt;
      ooc_r <= ocnt_nxt;
    end
  end

  assign out_valid        = ov_r;
  assign out_status       = ost_r;
  assign out_entry_count  = oec_r;
  assign out_output_count = ooc_r;

  `BBFV_ASSERT_IMP(a_stall_only_full, clk, rst_n, in_stall, out_valid, "stall without result")
  `BBFV_ASSERT_NXT(a_last_gives_result, clk, rst_n, accept && in_last, out_valid,
                   "last byte gave no result")
  `BBFV_ASSERT_NXT(a_clear_after_last, clk, rst_n, accept && in_last,
                   phase_r == bbfv_pkg::PH_VER && total_r == 21'd0, "stream not cleared")
  `BBFV_ASSERT_IMP(a_ok_has_counts, clk, rst_n, out_valid && out_status == bbfv_pkg::ST_OK,
                   out_entry_count != 21'd0 && out_output_count != 21'd0, "ok with zero count")

endmodule

FILE: test/bbfv_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbfv_stream_checker
// Watches the validator's ports, predicts each block status and compares.
// ----------------------------------------------------------------------------
module bbfv_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_status,
  input  logic [20:0] out_entry_count,
  input  logic [20:0] out_output_count,
  output int          n_fail,
  output int          n_wait
);

  localparam int unsigned IDW = bbfv_pkg::ID_BYTES_DEF;

  typedef struct packed {
    bbfv_pkg::status_t st;
    logic [20:0]       ents;
    logic [20:0]       outs;
  } verdict_t;

  verdict_t verdict_q[$];

  logic [7:0]  ver_r;
  int unsigned klen_r, maxlen_r;

  bbfv_pkg::phase_t  ph;
  int unsigned       fbc, need, total, left, maxdest, ent_n, out_n;
  logic [63:0]       acc;
  logic [7:0]        prev_id [IDW];
  bbfv_pkg::id_cmp_t cmp;
  logic              too_long;
  bbfv_pkg::status_t err;

  task automatic stream_clear();
    ph = bbfv_pkg::PH_VER; fbc = 0; need = 0; acc = '0; cmp = bbfv_pkg::CMP_EQUAL;
    total = 0; too_long = 1'b0; left = 0; maxdest = 0;
    ent_n = 0; out_n = 0; err = bbfv_pkg::ST_OK;
    for (int i = 0; i < IDW; i++) prev_id[i] = 8'h00;
  endtask

  task automatic fail(input bbfv_pkg::status_t code);
    err = code;
    ph = bbfv_pkg::PH_ERR;
  endtask

  function automatic bit fixed_done(input int unsigned len);
    fbc++;
    if (fbc >= len) begin
      fbc = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // 0 pending, 1 complete and valid, 2 complete and malformed
  task automatic size_feed(input logic [7:0] b, output int r, output logic [63:0] v);
    logic [63:0] lo;
    r = 0;
    v = '0;
    if (fbc == 0) begin
      if (b < 253) begin
        v = 64'(b);
        r = 1;
        return;
      end
      need = (b == 253) ? 2 : (b == 254) ? 4 : 8;
      acc = '0;
      fbc = 1;
      return;
    end
    acc |= 64'(b) << (8 * ((fbc - 1) & 7));
    fbc++;
    if (fbc - 1 < need) return;
    fbc = 0;
    lo = (need == 2) ? 64'd253 : (need == 4) ? 64'h1_0000 : 64'h1_0000_0000;
    if (acc < lo || acc > bbfv_pkg::SIZE_LIMIT) begin
      r = 2;
      return;
    end
    v = acc;
    r = 1;
  endtask

  task automatic start_entry();
    ph = bbfv_pkg::PH_EID;
    cmp = bbfv_pkg::CMP_EQUAL;
    fbc = 0;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    int          r;
    logic [63:0] v;
    bit          first;
    case (ph)
      bbfv_pkg::PH_VER: begin
        if (b != ver_r) fail(bbfv_pkg::ST_VERSION);
        else ph = bbfv_pkg::PH_BATCH;
      end
      bbfv_pkg::PH_BATCH: if (fixed_done(bbfv_pkg::HASH_BYTES)) ph = bbfv_pkg::PH_KLEN;
      bbfv_pkg::PH_KLEN: begin
        size_feed(b, r, v);
        if (r == 2) fail(bbfv_pkg::ST_MALFORMED);
        else if (r == 1) begin
          if (v > klen_r) fail(bbfv_pkg::ST_OVER_CAP);
          else if (v != klen_r) fail(bbfv_pkg::ST_KEY_LEN);
          else ph = (klen_r == 0) ? bbfv_pkg::PH_EXP : bbfv_pkg::PH_KEY;
        end
      end
      bbfv_pkg::PH_KEY:  if (fixed_done(klen_r)) ph = bbfv_pkg::PH_EXP;
      bbfv_pkg::PH_EXP:  if (fixed_done(4)) ph = bbfv_pkg::PH_ROOT;
      bbfv_pkg::PH_ROOT: if (fixed_done(bbfv_pkg::HASH_BYTES)) ph = bbfv_pkg::PH_NENT;
      bbfv_pkg::PH_NENT: begin
        size_feed(b, r, v);
        if (r == 2) fail(bbfv_pkg::ST_MALFORMED);
        else if (r == 1) begin
          if (v > maxlen_r) fail(bbfv_pkg::ST_OVER_CAP);
          else if (v == 0) fail(bbfv_pkg::ST_NO_ENTRY);
          else begin
            ent_n = 32'(v);
            left = ent_n;
            start_entry();
          end
        end
      end
      bbfv_pkg::PH_EID: begin
        first = (left == ent_n);
        if (fbc < IDW) begin
          if (!first && cmp == bbfv_pkg::CMP_EQUAL) begin
            if (prev_id[fbc] < b) cmp = bbfv_pkg::CMP_LESS;
            else if (prev_id[fbc] > b) cmp = bbfv_pkg::CMP_MORE;
          end
          prev_id[fbc] = b;
        end
        if (fixed_done(IDW)) ph = bbfv_pkg::PH_ECON;
      end
      bbfv_pkg::PH_ECON: begin
        if (fbc == 7 && b[7]) begin
          fbc = 0;
          fail(bbfv_pkg::ST_NEG_CONTR);
        end else if (fixed_done(8)) ph = bbfv_pkg::PH_EDEST;
      end
      bbfv_pkg::PH_EDEST: begin
        size_feed(b, r, v);
        if (r == 2) fail(bbfv_pkg::ST_MALFORMED);
        else if (r == 1) begin
          first = (left == ent_n);
          if (!first && cmp != bbfv_pkg::CMP_LESS) fail(bbfv_pkg::ST_ORDER);
          else begin
            if (v[31:0] > maxdest) maxdest = v[31:0];
            left--;
            if (left == 0) begin
              ph = bbfv_pkg::PH_NOUT;
              fbc = 0;
            end else start_entry();
          end
        end
      end
      bbfv_pkg::PH_NOUT: begin
        size_feed(b, r, v);
        if (r == 2) fail(bbfv_pkg::ST_MALFORMED);
        else if (r == 1) begin
          if (v > maxlen_r) fail(bbfv_pkg::ST_OVER_CAP);
          else if (v == 0) fail(bbfv_pkg::ST_NO_OUTPUT);
          else begin
            out_n = 32'(v);
            left = out_n;
            ph = bbfv_pkg::PH_OVAL;
            fbc = 0;
          end
        end
      end
      bbfv_pkg::PH_OVAL: begin
        if (fbc == 7 && b[7]) begin
          fbc = 0;
          fail(bbfv_pkg::ST_NEG_VALUE);
        end else if (fixed_done(8)) begin
          left--;
          if (left == 0) ph = bbfv_pkg::PH_DONE;
        end
      end
      bbfv_pkg::PH_DONE: fail(bbfv_pkg::ST_TRAILING);
      default: ;
    endcase
  endtask

  task automatic take_word(input logic [7:0] b, input logic lst);
    verdict_t e;
    if (total < bbfv_pkg::COUNT_MAX) total++;
    if (total > maxlen_r) too_long = 1'b1;
    decode_byte(b);
    if (!lst) return;
    if (too_long) e.st = bbfv_pkg::ST_TOO_LONG;
    else if (err != bbfv_pkg::ST_OK) e.st = err;
    else if (ph != bbfv_pkg::PH_DONE) e.st = bbfv_pkg::ST_TRUNC;
    else if (maxdest >= out_n) e.st = bbfv_pkg::ST_INDEX;
    else e.st = bbfv_pkg::ST_OK;
    e.ents = ent_n[20:0];
    e.outs = out_n[20:0];
    verdict_q = {verdict_q, e};
    stream_clear();
  endtask

  always @(posedge clk) begin
    verdict_t e;
    if (!rst_n) begin
      ver_r = 8'd1;
      klen_r = 897;
      maxlen_r = 65536;
      stream_clear();
      verdict_q.delete();
    end else begin
      // results first: a word taken on this edge cannot produce one yet
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected result, expected none, got %0d %0d %0d",
                   $time, out_status, out_entry_count, out_output_count);
        end else begin
          e = verdict_q.pop_front();
          if (out_status !== e.st || out_entry_count !== e.ents ||
              out_output_count !== e.outs) begin
            n_fail++;
            $display("%0t: mismatch expected status=%0d entries=%0d outputs=%0d, got %0d %0d %0d",
                     $time, e.st, e.ents, e.outs,
                     out_status, out_entry_count, out_output_count);
          end
        end
      end
      if (in_valid && !in_stall) take_word(in_data_byte, in_last);
      if (cfg_we) begin
        case (cfg_index)
          bbfv_pkg::CFG_VERSION: ver_r = cfg_wdata[7:0];
          bbfv_pkg::CFG_KEY_LEN: klen_r = 32'(cfg_wdata[11:0]);
          bbfv_pkg::CFG_MAX_LEN: maxlen_r = 32'(cfg_wdata);
          default: ;
        endcase
      end
    end
    n_wait = verdict_q.size();
  end

endmodule

FILE: test/batch_block_format_validator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batch_block_format_validator_core_test
// Stimulus and verdict for the batch block format validator.
// ----------------------------------------------------------------------------
// Builds serialized batch blocks, mostly well formed with random content and
// a share of broken ones (wrong version, bad sizes, disorder, negatives,
// cut short, trailing bytes), streams them one byte word at a time under
// random gaps and back pressure, and walks several register settings. The
// checker beside the block predicts every status word and compares.
// ----------------------------------------------------------------------------
module batch_block_format_validator_core_test;

  localparam logic [1:0] CFG_SPARE = 2'd3;  // not a register, must be ignored
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [20:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_status;
  logic [20:0] out_entry_count;
  logic [20:0] out_output_count;

  int n_fail, n_wait;

  // current register values, used to shape the blocks
  logic [7:0]  cur_ver = 8'd1;
  int unsigned cur_klen = 897;
  int unsigned cur_max = 65536;

  logic [7:0] blk[$];
  bit hold_req = 1'b0;
  bit holding = 1'b0;
  int idle_cnt = 0;

  batch_block_format_validator_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_entry_count(out_entry_count),
    .out_output_count(out_output_count)
  );

  bbfv_stream_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_entry_count(out_entry_count),
    .out_output_count(out_output_count),
    .n_fail(n_fail), .n_wait(n_wait)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Mostly no gap, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int r, k;
    forever begin
      if (hold_req) begin
        holding = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holding = 1'b0;
      end else begin
        r = $urandom_range(99);
        if (r < 40) begin
          out_stall <= 1'b0;
          k = $urandom_range(1, 20);
        end else if (r < 90) begin
          out_stall <= 1'b1;
          k = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          k = $urandom_range(20, 60);
        end
        repeat (k) @(posedge clk);
      end
    end
  end

  // Offer one word after an optional gap; return on the edge that takes it.
  // Valid is only dropped when a gap follows, so it never toggles in one step.
  task automatic send_word(input logic [7:0] b, input logic lst, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last <= lst;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_block();
    bit tight;
    tight = ($urandom_range(2) == 0);
    foreach (blk[i]) send_word(blk[i], i == blk.size() - 1, tight ? 0 : pick_gap());
  endtask

  // Hold off the sender until every result has come, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_wait != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [20:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input logic [7:0] v, input int unsigned k, input int unsigned m);
    drain();
    cfg_write(bbfv_pkg::CFG_VERSION, 21'(v));
    cfg_write(bbfv_pkg::CFG_KEY_LEN, 21'(k));
    cfg_write(bbfv_pkg::CFG_MAX_LEN, 21'(m));
    cur_ver = v;
    cur_klen = k;
    cur_max = m;
  endtask

  // Append one byte to the block under construction.
  task automatic put_byte(input logic [7:0] v);
    blk = {blk, v};
  endtask

  task automatic add_rand(input int unsigned n);
    repeat (n) put_byte(8'($urandom));
  endtask

  task automatic add_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) put_byte(v[8*i +: 8]);
  endtask

  // Compact size; stretch picks the next longer, non-canonical form.
  task automatic add_size(input logic [63:0] v, input bit stretch);
    int w;
    w = (v < 253) ? 1 : (v <= 64'hFFFF) ? 3 : (v <= 64'hFFFF_FFFF) ? 5 : 9;
    if (stretch && w < 9) w = (w == 1) ? 3 : (w == 3) ? 5 : 9;
    if (w == 1) put_byte(v[7:0]);
    else begin
      put_byte((w == 3) ? 8'd253 : (w == 5) ? 8'd254 : 8'd255);
      add_le(v, w - 1);
    end
  endtask

  function automatic logic [63:0] oversize();
    if ($urandom_range(1)) return bbfv_pkg::SIZE_LIMIT + 1 + $urandom_range(1000);
    return {$urandom, $urandom};
  endfunction

  // Eight-byte little-endian amount, occasionally with the sign bit set.
  task automatic add_amount();
    add_rand(7);
    put_byte(($urandom_range(99) < 5) ? 8'($urandom_range(128, 255))
                                      : 8'($urandom_range(0, 127)));
  endtask

  task automatic add_count(input int unsigned c);
    int r;
    r = $urandom_range(99);
    if (r < 3) add_size(oversize(), 1'b0);
    else add_size(64'(c), r < 8);
  endtask

  function automatic int unsigned pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 4) return 0;
    if (r < 8) return cur_max + 1 + $urandom_range(3);
    return $urandom_range(1, 2);
  endfunction

  task automatic build_block();
    int unsigned n, m;
    int r, p, tries;
    logic [7:0] id [bbfv_pkg::ID_BYTES_DEF];
    logic [7:0] pid [bbfv_pkg::ID_BYTES_DEF];
    blk.delete();
    put_byte(($urandom_range(99) < 94) ? cur_ver : 8'($urandom));
    add_rand(bbfv_pkg::HASH_BYTES);
    r = $urandom_range(99);
    if (r < 85) add_size(64'(cur_klen), $urandom_range(19) == 0);
    else if (r < 90) add_size(64'(cur_klen + 1), 1'b0);
    else if (r < 95) add_size(64'($urandom_range(4095)), 1'b0);
    else add_size(oversize(), 1'b0);
    add_rand(cur_klen);
    add_rand(4 + bbfv_pkg::HASH_BYTES);
    n = pick_count();
    m = pick_count();
    add_count(n);
    for (int i = 0; i < n && i < 5; i++) begin
      r = $urandom_range(99);
      if (i == 0) begin
        foreach (id[k]) id[k] = (r < 5) ? 8'hFF : (r < 10) ? 8'h00 :
                                (k == 0) ? 8'($urandom_range(200)) : 8'($urandom);
      end else if (r < 8) begin
        id = pid;                                // equal: order error
      end else if (r < 16) begin
        foreach (id[k]) id[k] = 8'($urandom);    // likely out of order
      end else begin
        // raise one byte, keep the ones ahead, randomize the ones after
        id = pid;
        p = $urandom_range(bbfv_pkg::ID_BYTES_DEF - 1);
        for (tries = 0; tries < bbfv_pkg::ID_BYTES_DEF && pid[p] == 8'hFF; tries++)
          p = (p + 1) % bbfv_pkg::ID_BYTES_DEF;
        if (pid[p] != 8'hFF) begin
          id[p] = 8'($urandom_range(pid[p] + 1, 255));
          for (int k = p + 1; k < bbfv_pkg::ID_BYTES_DEF; k++) id[k] = 8'($urandom);
        end
      end
      foreach (id[k]) put_byte(id[k]);
      pid = id;
      add_amount();
      r = $urandom_range(99);
      if (r < 85) add_size(64'($urandom_range(0, (m > 0 && m < 5) ? m - 1 : 3)), 1'b0);
      else if (r < 93) add_size(64'(m + $urandom_range(300)), 1'b0);
      else if (r < 97) add_size(64'($urandom_range(300)), 1'b1);
      else add_size(oversize(), 1'b0);
    end
    add_count(m);
    for (int i = 0; i < m && i < 5; i++) add_amount();
    r = $urandom_range(99);
    if (r < 10 && blk.size() > 1) begin
      n = $urandom_range(1, blk.size() - 1);
      while (blk.size() > n) void'(blk.pop_back());
    end else if (r < 18) begin
      add_rand($urandom_range(1, 3));
    end else if (r < 23) begin
      blk[$urandom_range(blk.size() - 1)] = 8'($urandom);
    end
  endtask

  task automatic run_blocks(input int cnt);
    repeat (cnt) begin
      build_block();
      send_block();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short directed blocks on the reset settings: wrong version at both
    // extremes, a lone good version (truncated), version then a cut batch id.
    blk = {8'h00};               send_block();
    blk = {8'hFF};               send_block();
    blk = {8'h01};               send_block();
    blk = {8'h01, 8'hFF};        send_block();
    blk = {8'h01, 8'h00, 8'h80}; send_block();
    drain();

    set_regs(8'($urandom), $urandom_range(0, 6), 65536);
    run_blocks(1);
    drain();

    // Fill the block: hold the receiver off and keep offering one-word blocks.
    hold_req = 1'b1;
    do @(posedge clk); while (!holding);
    repeat (30) send_word(8'($urandom), 1'b1, 0);
    drain();
    run_blocks(1);

    set_regs(8'h00, 0, 1048576);
    run_blocks(1);

    set_regs(8'($urandom), 3, 1);
    cfg_write(CFG_SPARE, 21'($urandom));
    run_blocks(1);

    drain();
    repeat (5) @(posedge clk);
    if (n_fail == 0 && n_wait == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
